// File: sv/rrt_pkg.sv
// Shared types and constants for the register rename table.
`timescale 1ns / 1ps

package rrt_pkg;

  localparam int ARCH_W   = 5;
  localparam int PHYS_W   = 7;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 3;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int ARCH_CODES = 1 << ARCH_W;

  localparam logic [MODE_W-1:0] MODE_RENAME     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RENAME_REL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_EN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_IDX = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ARCH_W-1:0] arch_idx;
    logic [PHYS_W-1:0] phys_idx;
  } rrt_in_t;

  typedef struct packed {
    logic [PHYS_W-1:0]   new_phys;
    logic [PHYS_W-1:0]   prev_phys;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    free_count;
  } rrt_out_t;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [PHYS_W-1:0] push_data;
  } rrt_fl_req_t;

endpackage

// File: sv/register_rename_table.sv
// Register rename table top level: control sequencer, configuration and result register.
// A result is registered when an accepted request fires in the execute state; firing
// waits while the output is stalled, and no new beat is accepted until then. The map
// and free-list memory reads happen on acceptance, the read-modify-write of both on firing.
// Reset clears control state at once; the map reads as identity through its valid bits
// and the free list holds the initial registers via a fill count, with no clearing pass.
`timescale 1ns / 1ps

module register_rename_table #(
  parameter int ARCH_REGS = 32,
  parameter int PHYS_REGS = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rrt_pkg::rrt_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rrt_pkg::rrt_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [rrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrt_pkg::CFG_W-1:0]     cfg_data
);
  import rrt_pkg::*;

  localparam int AW = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;
  localparam int PW = (PHYS_REGS > 1) ? $clog2(PHYS_REGS) : 1;
  localparam int CW = $clog2(PHYS_REGS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(PHYS_REGS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  typedef logic [ARCH_CODES-1:0][AW-1:0] mod_tab_t;

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int i = 0; i < ARCH_CODES; i++) begin
      tab[i] = AW'(i % ARCH_REGS);
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  logic              state_r, state_nxt;
  rrt_in_t           req_r;
  logic [AW-1:0]     addr_r;
  logic              zero_en_r;
  logic [ARCH_W-1:0] zero_idx_r;
  logic              out_valid_r;
  rrt_out_t          out_r, out_nxt;

  logic              accept;
  logic              fire;
  logic [AW-1:0]     in_addr;
  logic [PHYS_W-1:0] map_rd;
  logic [PHYS_W-1:0] fl_rd;
  logic [CW-1:0]     fl_total;
  logic              map_we;
  logic [PHYS_W-1:0] map_wd;
  rrt_fl_req_t       fl_req;
  logic              is_zero;
  logic              fl_empty;
  logic              fl_full;
  logic [CW-1:0]     total_after;

  assign in_addr  = MOD_TAB[in_data.arch_idx];
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  rrt_map_table #(
    .ARCH_REGS(ARCH_REGS),
    .AW(AW)
  ) u_map (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(accept),
    .rd_addr(in_addr),
    .rd_data(map_rd),
    .wr_en(map_we),
    .wr_addr(addr_r),
    .wr_data(map_wd)
  );

  rrt_free_list #(
    .ARCH_REGS(ARCH_REGS),
    .PHYS_REGS(PHYS_REGS),
    .PW(PW),
    .CW(CW)
  ) u_free (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(accept),
    .req(fl_req),
    .rd_data(fl_rd),
    .total(fl_total)
  );

  assign is_zero  = zero_en_r && (req_r.arch_idx == zero_idx_r);
  assign fl_empty = (fl_total == '0);
  assign fl_full  = (fl_total >= CNT_FULL);

  always_comb begin
    map_we           = 1'b0;
    map_wd           = req_r.phys_idx;
    fl_req.pop       = 1'b0;
    fl_req.push      = 1'b0;
    fl_req.push_data = req_r.phys_idx;
    out_nxt.new_phys  = '0;
    out_nxt.prev_phys = '0;
    out_nxt.status    = STATUS_OK;
    case (req_r.mode)
      MODE_RENAME, MODE_RENAME_REL: begin
        out_nxt.prev_phys = map_rd;
        if (is_zero) begin
          out_nxt.new_phys  = PHYS_W'(zero_idx_r);
          out_nxt.prev_phys = PHYS_W'(zero_idx_r);
        end else if (fl_empty) begin
          out_nxt.new_phys = map_rd;
          out_nxt.status   = STATUS_EMPTY;
        end else begin
          out_nxt.new_phys = fl_rd;
          map_we           = fire;
          map_wd           = fl_rd;
          fl_req.pop       = fire;
          if (req_r.mode == MODE_RENAME_REL) begin
            fl_req.push      = fire;
            fl_req.push_data = map_rd;
          end
        end
      end
      MODE_LOOKUP: begin
        out_nxt.new_phys  = map_rd;
        out_nxt.prev_phys = map_rd;
      end
      MODE_SET: begin
        out_nxt.prev_phys = map_rd;
        out_nxt.new_phys  = req_r.phys_idx;
        map_we            = fire;
      end
      MODE_RELEASE: begin
        if (fl_full) begin
          out_nxt.status = STATUS_FULL;
        end else begin
          fl_req.push = fire;
        end
      end
      default: begin
        out_nxt.status = STATUS_OK;
      end
    endcase
    total_after = fl_total;
    if (fl_req.push && !fl_req.pop) begin
      total_after = fl_total + CW'(1);
    end else if (fl_req.pop && !fl_req.push) begin
      total_after = fl_total - CW'(1);
    end
    out_nxt.free_count = CNT_W'(total_after);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_data;
      addr_r <= in_addr;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      zero_en_r   <= 1'b1;
      zero_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZERO_EN:  zero_en_r  <= cfg_data[0];
          CFG_ZERO_IDX: zero_idx_r <= cfg_data[ARCH_W-1:0];
          default: begin
            zero_en_r <= zero_en_r;
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/rrt_map_table.sv
// Architectural-to-physical map memory with per-entry valid bits for reset.
`timescale 1ns / 1ps

module rrt_map_table #(
  parameter int ARCH_REGS = 32,
  parameter int AW = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rrt_pkg::PHYS_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rrt_pkg::PHYS_W-1:0] wr_data
);
  import rrt_pkg::*;

  logic [PHYS_W-1:0]    mem [ARCH_REGS];
  logic [ARCH_REGS-1:0] valid_r;
  logic [PHYS_W-1:0]    rd_mem_r;
  logic                 rd_valid_r;
  logic [AW-1:0]        rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r  <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_mem_r : PHYS_W'(rd_addr_r);

endmodule

// File: sv/rrt_free_list.sv
// Circular free list of physical registers with pointers, count and fill tracking.
`timescale 1ns / 1ps

module rrt_free_list #(
  parameter int ARCH_REGS = 32,
  parameter int PHYS_REGS = 128,
  parameter int PW = 7,
  parameter int CW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  rrt_pkg::rrt_fl_req_t       req,
  output logic [rrt_pkg::PHYS_W-1:0] rd_data,
  output logic [CW-1:0]              total
);
  import rrt_pkg::*;

  localparam int INIT_N = (PHYS_REGS > ARCH_REGS) ? (PHYS_REGS - ARCH_REGS) : 0;
  localparam logic [PW-1:0]     PTR_LAST = PW'(PHYS_REGS - 1);
  localparam logic [CW-1:0]     INIT_CNT = CW'(INIT_N);
  localparam logic [PHYS_W-1:0] ARCH_BASE = PHYS_W'(ARCH_REGS);

  logic [PHYS_W-1:0] mem [PHYS_REGS];
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [PHYS_W-1:0] rd_mem_r;
  logic [PHYS_W-1:0] rd_init_val_r;
  logic              rd_init_r;
  logic              head_init;

  assign head_init = (CW'(head_r) >= fill_r) && (CW'(head_r) < INIT_CNT);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    fill_nxt  = fill_r;
    if (req.pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PW'(1);
    end
    if (req.push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PW'(1);
      if ((CW'(tail_r) == fill_r) && (fill_r < INIT_CNT)) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
    if (req.push && !req.pop) begin
      total_nxt = total_r + CW'(1);
    end else if (req.pop && !req.push) begin
      total_nxt = total_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.push_data;
    end
    if (rd_en) begin
      rd_mem_r      <= mem[head_r];
      rd_init_val_r <= ARCH_BASE + PHYS_W'(head_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= PW'(INIT_N);
      total_r   <= INIT_CNT;
      fill_r    <= '0;
      rd_init_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
      fill_r  <= fill_nxt;
      if (rd_en) begin
        rd_init_r <= head_init;
      end
    end
  end

  assign rd_data = rd_init_r ? rd_init_val_r : rd_mem_r;
  assign total   = total_r;

endmodule
